// File: rtl/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg: shared definitions for the nearest timestamp sample lookup
// Table geometry, field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int TIME_BITS   = 48;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = IDX_BITS + 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [TIME_BITS:0]   diff_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_SCAN,
    S_PICK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// File: rtl/nts_ram.sv
// ----------------------------------------------------------------------------
// nts_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/nearest_timestamp_sample_lookup.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_sample_lookup: table of sample times with nearest query
// Appends timestamps in arrival order and answers nearest-entry queries.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: op, sample_time, qualified by in_valid; the block raises
//   in_stall while it works on a request. Result channel: status,
//   entry_index, entry_time, entry_count, qualified by out_valid; the
//   receiver raises out_stall to hold a result, which then stays unchanged.
//   One result per request, in request order.
//   Append, clear, the unused op code and a query on an empty table go
//   straight from the idle state to the response state, which loads the
//   result into the output register once that register is free.
//   A query reads the last entry, then scans the table from the start, one
//   RAM read per cycle through the single read port. A query past the last
//   entry, or on a single entry, answers after that first read, with no scan.
//   Otherwise the scan runs to the first entry at or after the query time,
//   and the nearer of that entry and its predecessor is picked.
//   One request is in work at a time; the next request is taken as soon as
//   the previous result sits in the output register, even while it is stalled.
//   Reset clears the fill count, the sequencer and the output valid; the table
//   RAM is not cleared, since only entries below the fill count are used.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_timestamp_sample_lookup (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [47:0] sample_time,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [9:0]       entry_index,
  output logic [47:0]      entry_time,
  output logic [10:0]      entry_count
);

  nts_pkg::state_t state, state_next;

  nts_pkg::cnt_t    fill_count;
  nts_pkg::time_t   req_time;
  nts_pkg::time_t   prev_time;
  nts_pkg::time_t   cur_time;
  nts_pkg::idx_t    scan_idx;
  nts_pkg::diff_t   before_d;
  nts_pkg::diff_t   after_d;
  nts_pkg::status_t res_status;
  nts_pkg::idx_t    res_index;
  nts_pkg::time_t   res_time;

  // RAM port signals
  logic           ram_we;
  nts_pkg::idx_t  ram_waddr;
  nts_pkg::idx_t  ram_raddr;
  nts_pkg::time_t rdata;

  logic         accept;
  logic         out_free;
  logic         full;
  logic         hit;
  nts_pkg::op_t req_op;

  assign req_op   = nts_pkg::op_t'(op);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = (fill_count >= nts_pkg::CNT_BITS'(nts_pkg::TABLE_DEPTH));
  // First entry at or after the query time
  assign hit      = (rdata >= req_time);

  nts_ram #(
    .WIDTH (nts_pkg::TIME_BITS),
    .DEPTH (nts_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sample_time),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      nts_pkg::S_IDLE: begin
        if (accept) begin
          if (req_op == nts_pkg::OP_QUERY && fill_count != '0) begin
            state_next = nts_pkg::S_LAST;
          end else begin
            state_next = nts_pkg::S_RESP;
          end
        end
      end
      nts_pkg::S_LAST: begin
        // Past the last entry, or a single entry: answer now
        if (req_time > rdata || fill_count == nts_pkg::CNT_BITS'(1)) begin
          state_next = nts_pkg::S_RESP;
        end else begin
          state_next = nts_pkg::S_FIRST;
        end
      end
      nts_pkg::S_FIRST: state_next = nts_pkg::S_SCAN;
      nts_pkg::S_SCAN: begin
        if (hit) begin
          state_next = nts_pkg::S_PICK;
        end
      end
      nts_pkg::S_PICK: state_next = nts_pkg::S_RESP;
      nts_pkg::S_RESP: begin
        if (out_free) begin
          state_next = nts_pkg::S_IDLE;
        end
      end
      default: state_next = nts_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and RAM control
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = fill_count[nts_pkg::IDX_BITS-1:0];
    ram_raddr = '0;
    case (state)
      nts_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        ram_we    = accept && req_op == nts_pkg::OP_APPEND && !full;
        // Fetch the last entry ahead of a possible query
        ram_raddr = fill_count[nts_pkg::IDX_BITS-1:0] - nts_pkg::IDX_BITS'(1);
      end
      nts_pkg::S_LAST:  ram_raddr = '0;
      nts_pkg::S_FIRST: ram_raddr = nts_pkg::IDX_BITS'(1);
      nts_pkg::S_SCAN:  ram_raddr = scan_idx + nts_pkg::IDX_BITS'(1);
      default:          ram_raddr = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nts_pkg::S_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == nts_pkg::S_IDLE && accept) begin
        case (req_op)
          nts_pkg::OP_APPEND: begin
            if (!full) begin
              fill_count <= fill_count + nts_pkg::CNT_BITS'(1);
            end
          end
          nts_pkg::OP_CLEAR: fill_count <= '0;
          default: ;
        endcase
      end
      if (state == nts_pkg::S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      nts_pkg::S_IDLE: begin
        if (accept) begin
          req_time  <= sample_time;
          res_index <= '0;
          res_time  <= '0;
          case (req_op)
            nts_pkg::OP_APPEND: res_status <= full ? nts_pkg::STAT_FULL : nts_pkg::STAT_OK;
            nts_pkg::OP_QUERY:
              res_status <= (fill_count == '0) ? nts_pkg::STAT_NONE : nts_pkg::STAT_OK;
            default: res_status <= nts_pkg::STAT_OK;
          endcase
        end
      end
      nts_pkg::S_LAST: begin
        if (req_time > rdata) begin
          res_status <= nts_pkg::STAT_NONE;
        end else if (fill_count == nts_pkg::CNT_BITS'(1)) begin
          res_time <= rdata;
        end
      end
      nts_pkg::S_FIRST: begin
        prev_time <= rdata;
        scan_idx  <= nts_pkg::IDX_BITS'(1);
      end
      nts_pkg::S_SCAN: begin
        cur_time <= rdata;
        before_d <= {1'b0, req_time} - {1'b0, prev_time};
        after_d  <= {1'b0, rdata} - {1'b0, req_time};
        if (!hit) begin
          // Advance: current entry becomes the predecessor
          prev_time <= rdata;
          scan_idx  <= scan_idx + nts_pkg::IDX_BITS'(1);
        end
      end
      nts_pkg::S_PICK: begin
        // Ties go to the later entry
        if ($signed(before_d) < $signed(after_d)) begin
          res_index <= scan_idx - nts_pkg::IDX_BITS'(1);
          res_time  <= prev_time;
        end else begin
          res_index <= scan_idx;
          res_time  <= cur_time;
        end
      end
      default: ;
    endcase
  end

  // Output register: load only when free, so a stalled result holds
  always_ff @(posedge clk) begin
    if (state == nts_pkg::S_RESP && out_free) begin
      status      <= res_status;
      entry_index <= res_index;
      entry_time  <= res_time;
      entry_count <= fill_count;
    end
  end

endmodule

`default_nettype wire
